// File: src/itoaf_pkg.sv
// ----------------------------------------------------------------------------
// itoaf_pkg
// Shared types, character codes and radix constants for the integer
// formatter.
// ----------------------------------------------------------------------------
package itoaf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_PRIME,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_MINUS,
        KIND_SPACE,
        KIND_ZERO
    } kind_t;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [3:0] DEC_RADIX  = 4'd10;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d <= DIGIT_MAX)
        begin
            c = CHAR_ZERO + {4'b0, d};
        end
        else if (upper)
        begin
            c = CHAR_UPPER_A + {4'b0, d - DEC_RADIX};
        end
        else
        begin
            c = CHAR_LOWER_A + {4'b0, d - DEC_RADIX};
        end
        return c;
    endfunction

endpackage

// File: src/itoaf_ram.sv
// ----------------------------------------------------------------------------
// itoaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itoaf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/itoaf_div.sv
// ----------------------------------------------------------------------------
// itoaf_div
// Shared digit divider: splits a value into quotient and low digit for the
// selected radix. Decimal uses a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module itoaf_div #(
    parameter int MAG_BITS = 32
) (
    input  logic                clk,
    input  logic                mul_en,
    input  logic [MAG_BITS-1:0] dividend,
    input  logic [1:0]          base_sel,
    output logic [MAG_BITS-1:0] quotient,
    output logic [3:0]          remainder
);

    localparam int PROD_BITS = MAG_BITS + 32;

    logic [PROD_BITS-1:0] prod_reg;
    logic [PROD_BITS-1:0] prod_next;
    logic [MAG_BITS-1:0]  q_dec;
    logic [MAG_BITS-1:0]  r_dec;

    assign prod_next = PROD_BITS'(dividend) * PROD_BITS'(itoaf_pkg::RECIP_10);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign q_dec = MAG_BITS'(prod_reg >> itoaf_pkg::RECIP_SHIFT);
    assign r_dec = dividend - (q_dec << 3) - (q_dec << 1);

    always_comb
    begin
        case (base_sel)
            itoaf_pkg::BASE_BIN:
            begin
                quotient  = dividend >> 1;
                remainder = {3'b0, dividend[0]};
            end
            itoaf_pkg::BASE_OCT:
            begin
                quotient  = dividend >> 3;
                remainder = {1'b0, dividend[2:0]};
            end
            itoaf_pkg::BASE_DEC:
            begin
                quotient  = q_dec;
                remainder = r_dec[3:0];
            end
            default:
            begin
                quotient  = dividend >> 4;
                remainder = dividend[3:0];
            end
        endcase
    end

endmodule

// File: src/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one unsigned magnitude as a padded, signed ASCII integer field,
// one character per output request, most significant first.
// ----------------------------------------------------------------------------
// Digit extraction: in decimal each digit passes ST_MUL (multiply) and then
// ST_FIX (fix-up in the shared divider); binary, octal and hex use ST_FIX alone.
// Then ST_PRIME primes the digit RAM read, then 1 character per cycle while
// char_stall is low; one request at a time.
// Reset clears the sequencer to idle; the digit RAM is not cleared.
module integer_to_ascii_formatter_core #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [31:0] magnitude,
    input  logic [1:0]  base_sel,
    input  logic        negative,
    input  logic [6:0]  field_width,
    input  logic        left_adjust,
    input  logic        zero_pad,
    input  logic        upper_case,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [7:0]  out_char,
    output logic        last_char
);

    localparam int MAG_BITS  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int DEPTH     = VALUE_BITS;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int ND_BITS   = $clog2(DEPTH + 1);
    localparam int OUT_MAX   = ((VALUE_BITS + 1) > MAX_WIDTH) ? (VALUE_BITS + 1) : MAX_WIDTH;
    localparam int LEN_BITS  = $clog2(OUT_MAX + 1);

    typedef struct packed {
        itoaf_pkg::kind_t      kind;
        logic [LEN_BITS-1:0]   rel;
    } plan_t;

    itoaf_pkg::state_t   state_reg, state_next;
    logic [MAG_BITS-1:0] q_reg, q_next;
    logic [ND_BITS-1:0]  nd_reg, nd_next;
    logic [LEN_BITS-1:0] pos_reg, pos_next;
    logic [1:0]          base_reg, base_next;
    logic                neg_reg, neg_next;
    logic [LEN_BITS-1:0] width_reg, width_next;
    logic                left_reg, left_next;
    logic                zero_reg, zero_next;
    logic                upper_reg, upper_next;

    logic                mul_en;
    logic [MAG_BITS-1:0] div_q;
    logic [3:0]          div_r;
    logic                wr_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [3:0]          rd_data;

    logic [LEN_BITS-1:0] nd_len;
    logic [LEN_BITS-1:0] actual;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] pad;
    logic                is_last;
    logic                out_take;
    plan_t               plan_cur;
    plan_t               plan_nxt;

    function automatic plan_t plan_at(input logic [LEN_BITS-1:0] pos);
        plan_t               p;
        logic [LEN_BITS-1:0] j;
        p.kind = itoaf_pkg::KIND_DIGIT;
        p.rel  = '0;
        j      = pos - LEN_BITS'(neg_reg);
        if (left_reg)
        begin
            if (neg_reg && (pos == '0))
                p.kind = itoaf_pkg::KIND_MINUS;
            else if (j < nd_len)
                p.rel = j;
            else
                p.kind = itoaf_pkg::KIND_SPACE;
        end
        else if (zero_reg)
        begin
            if (neg_reg && (pos == '0))
                p.kind = itoaf_pkg::KIND_MINUS;
            else if (j < pad)
                p.kind = itoaf_pkg::KIND_ZERO;
            else
                p.rel = j - pad;
        end
        else
        begin
            if (pos < pad)
                p.kind = itoaf_pkg::KIND_SPACE;
            else if (neg_reg && (pos == pad))
                p.kind = itoaf_pkg::KIND_MINUS;
            else
                p.rel = pos - pad - LEN_BITS'(neg_reg);
        end
        return p;
    endfunction

    itoaf_div #(
        .MAG_BITS (MAG_BITS)
    ) u_div (
        .clk       (clk),
        .mul_en    (mul_en),
        .dividend  (q_reg),
        .base_sel  (base_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    itoaf_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_digits (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (nd_reg[ADDR_BITS-1:0]),
        .wr_data (div_r),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign nd_len  = LEN_BITS'(nd_reg);
    assign actual  = nd_len + LEN_BITS'(neg_reg);
    assign len     = (width_reg > actual) ? width_reg : actual;
    assign pad     = len - actual;
    assign is_last = (pos_reg == (len - LEN_BITS'(1)));

    assign req_stall  = (state_reg != itoaf_pkg::ST_IDLE);
    assign char_valid = (state_reg == itoaf_pkg::ST_EMIT);
    assign out_take   = char_valid && !char_stall;
    assign last_char  = is_last;

    always_comb
    begin
        plan_cur = plan_at(pos_reg);
        plan_nxt = plan_at(pos_next);
    end

    assign rd_addr  = ADDR_BITS'(nd_len - LEN_BITS'(1) - plan_nxt.rel);

    always_comb
    begin
        case (plan_cur.kind)
            itoaf_pkg::KIND_MINUS: out_char = itoaf_pkg::CHAR_MINUS;
            itoaf_pkg::KIND_SPACE: out_char = itoaf_pkg::CHAR_SPACE;
            itoaf_pkg::KIND_ZERO:  out_char = itoaf_pkg::CHAR_ZERO;
            default:
                out_char = itoaf_pkg::digit_char(rd_data,
                    upper_reg && (base_reg == itoaf_pkg::BASE_HEX));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoaf_pkg::ST_IDLE;
            q_reg     <= '0;
            nd_reg    <= '0;
            pos_reg   <= '0;
            base_reg  <= '0;
            neg_reg   <= 1'b0;
            width_reg <= '0;
            left_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            upper_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            nd_reg    <= nd_next;
            pos_reg   <= pos_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            width_reg <= width_next;
            left_reg  <= left_next;
            zero_reg  <= zero_next;
            upper_reg <= upper_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        nd_next    = nd_reg;
        pos_next   = pos_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        width_next = width_reg;
        left_next  = left_reg;
        zero_next  = zero_reg;
        upper_next = upper_reg;
        mul_en     = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            itoaf_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    q_next     = magnitude[MAG_BITS-1:0];
                    nd_next    = '0;
                    base_next  = base_sel;
                    neg_next   = negative;
                    width_next = (32'(field_width) > MAX_WIDTH) ? LEN_BITS'(MAX_WIDTH)
                                                               : LEN_BITS'(field_width);
                    left_next  = left_adjust;
                    zero_next  = zero_pad;
                    upper_next = upper_case;
                    state_next = (base_sel == itoaf_pkg::BASE_DEC) ? itoaf_pkg::ST_MUL
                                                                   : itoaf_pkg::ST_FIX;
                end
            end
            itoaf_pkg::ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = itoaf_pkg::ST_FIX;
            end
            itoaf_pkg::ST_FIX:
            begin
                wr_en   = 1'b1;
                q_next  = div_q;
                nd_next = nd_reg + ND_BITS'(1);
                if ((div_q == '0) || ((32'(nd_reg) + 1) == DEPTH))
                    state_next = itoaf_pkg::ST_PRIME;
                else if (base_reg == itoaf_pkg::BASE_DEC)
                    state_next = itoaf_pkg::ST_MUL;
            end
            itoaf_pkg::ST_PRIME:
            begin
                pos_next   = '0;
                state_next = itoaf_pkg::ST_EMIT;
            end
            itoaf_pkg::ST_EMIT:
            begin
                if (out_take)
                begin
                    if (is_last)
                        state_next = itoaf_pkg::ST_IDLE;
                    else
                        pos_next = pos_reg + LEN_BITS'(1);
                end
            end
            default:
            begin
                state_next = itoaf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: dv/tb_integer_to_ascii_formatter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_core
// Self-checking bench for the integer formatter: directed corner fields
// (radix extremes, every padding mode, width saturation) and then random
// requests under three stall/idle mixes. A local formatter predicts every
// character and the last-character mark, and each output is checked in order.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_core;

    typedef struct packed {
        logic [31:0] magnitude;
        logic [1:0]  base_sel;
        logic        negative;
        logic [6:0]  field_width;
        logic        left_adjust;
        logic        zero_pad;
        logic        upper_case;
    } fmt_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fmt_char_t;

    localparam int FIELD_MAX = 64;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [31:0] magnitude;
    logic [1:0]  base_sel;
    logic        negative;
    logic [6:0]  field_width;
    logic        left_adjust;
    logic        zero_pad;
    logic        upper_case;
    logic        char_valid;
    logic        char_stall;
    logic [7:0]  out_char;
    logic        last_char;

    fmt_char_t   pending_chars[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          n_fields;
    int          n_chars;
    int          n_fail;
    fmt_char_t   want;

    integer_to_ascii_formatter_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .magnitude   (magnitude),
        .base_sel    (base_sel),
        .negative    (negative),
        .field_width (field_width),
        .left_adjust (left_adjust),
        .zero_pad    (zero_pad),
        .upper_case  (upper_case),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .last_char   (last_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] ascii_of_digit(input logic [3:0] d, input logic upper);
        if (d < 4'd10)
        begin
            return itoaf_pkg::CHAR_ZERO + 8'(d);
        end
        return (upper ? itoaf_pkg::CHAR_UPPER_A : itoaf_pkg::CHAR_LOWER_A) + 8'(d) - 8'd10;
    endfunction

    function automatic void predict_field(input fmt_req_t r);
        logic [31:0] quot;
        logic [31:0] radix;
        logic [3:0]  digs[32];
        logic [7:0]  line[$];
        int          nd;
        int          width;
        int          actual;
        int          pad;
        case (r.base_sel)
            itoaf_pkg::BASE_BIN: radix = 32'd2;
            itoaf_pkg::BASE_OCT: radix = 32'd8;
            itoaf_pkg::BASE_DEC: radix = 32'd10;
            default:             radix = 32'd16;
        endcase
        quot = r.magnitude;
        nd = 0;
        do
        begin
            digs[nd] = 4'(quot % radix);
            nd++;
            quot = quot / radix;
        end
        while (quot != 0 && nd < 32);
        width = (int'(r.field_width) > FIELD_MAX) ? FIELD_MAX : int'(r.field_width);
        actual = nd + int'(r.negative);
        pad = (width > actual) ? width - actual : 0;
        if (!r.left_adjust && !r.zero_pad)
        begin
            repeat (pad) line.push_back(itoaf_pkg::CHAR_SPACE);
        end
        if (r.negative)
        begin
            line.push_back(itoaf_pkg::CHAR_MINUS);
        end
        if (!r.left_adjust && r.zero_pad)
        begin
            repeat (pad) line.push_back(itoaf_pkg::CHAR_ZERO);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            line.push_back(ascii_of_digit(digs[i], r.upper_case));
        end
        if (r.left_adjust)
        begin
            repeat (pad) line.push_back(itoaf_pkg::CHAR_SPACE);
        end
        foreach (line[i])
        begin
            pending_chars.push_back('{ch: line[i], last: (i == line.size() - 1)});
        end
    endfunction

    function automatic fmt_req_t make_req(input logic [31:0] mag, input logic [1:0] base,
                                          input logic neg, input logic [6:0] width,
                                          input logic left, input logic zp, input logic up);
        return '{magnitude: mag, base_sel: base, negative: neg, field_width: width,
                 left_adjust: left, zero_pad: zp, upper_case: up};
    endfunction

    task automatic send_request(input fmt_req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid   <= 1'b1;
        magnitude   <= r.magnitude;
        base_sel    <= r.base_sel;
        negative    <= r.negative;
        field_width <= r.field_width;
        left_adjust <= r.left_adjust;
        zero_pad    <= r.zero_pad;
        upper_case  <= r.upper_case;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_field(r);
        n_fields++;
    endtask

    always @(posedge clk)
    begin
        char_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
        begin
            n_chars++;
            if (pending_chars.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("[%0t] unexpected char 0x%02h last=%0b", $realtime, out_char,
                             last_char);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch || last_char !== want.last)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("[%0t] char mismatch: exp 0x%02h last=%0b, got 0x%02h last=%0b",
                                 $realtime, want.ch, want.last, out_char, last_char);
                end
            end
        end
    end

    task automatic test_radix_extremes();
        send_request(make_req(32'd0, itoaf_pkg::BASE_DEC, 1'b0, 7'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_req(32'hFFFF_FFFF, itoaf_pkg::BASE_BIN, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b0));
        send_request(make_req(32'hFFFF_FFFF, itoaf_pkg::BASE_OCT, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b0));
        send_request(make_req(32'hFFFF_FFFF, itoaf_pkg::BASE_DEC, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b0));
        send_request(make_req(32'hFFFF_FFFF, itoaf_pkg::BASE_HEX, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b1));
        send_request(make_req(32'hDEAD_BEEF, itoaf_pkg::BASE_HEX, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b0));
        send_request(make_req(32'hABCD_EF01, itoaf_pkg::BASE_HEX, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b1));
        send_request(make_req(32'h8000_0000, itoaf_pkg::BASE_BIN, 1'b1, 7'd0, 1'b0, 1'b0,
                              1'b0));
        send_request(make_req(32'd1000000000, itoaf_pkg::BASE_DEC, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b1));
        send_request(make_req(32'd10, itoaf_pkg::BASE_DEC, 1'b0, 7'd0, 1'b0, 1'b0, 1'b1));
        send_request(make_req(32'h0000_00AF, itoaf_pkg::BASE_OCT, 1'b0, 7'd0, 1'b0, 1'b0,
                              1'b1));
    endtask

    task automatic test_padding_modes();
        send_request(make_req(32'd42, itoaf_pkg::BASE_DEC, 1'b1, 7'd8, 1'b0, 1'b1, 1'b0));
        send_request(make_req(32'd42, itoaf_pkg::BASE_DEC, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0));
        send_request(make_req(32'd42, itoaf_pkg::BASE_DEC, 1'b1, 7'd8, 1'b1, 1'b1, 1'b0));
        send_request(make_req(32'd42, itoaf_pkg::BASE_DEC, 1'b0, 7'd8, 1'b1, 1'b0, 1'b0));
        send_request(make_req(32'd0, itoaf_pkg::BASE_HEX, 1'b1, 7'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_req(32'hBEEF, itoaf_pkg::BASE_HEX, 1'b0, 7'd10, 1'b0, 1'b1, 1'b1));
        send_request(make_req(32'd123456, itoaf_pkg::BASE_DEC, 1'b1, 7'd3, 1'b0, 1'b1,
                              1'b0));
    endtask

    task automatic test_width_limits();
        send_request(make_req(32'hFFFF_FFFF, itoaf_pkg::BASE_BIN, 1'b1, 7'd64, 1'b0, 1'b1,
                              1'b0));
        send_request(make_req(32'd7, itoaf_pkg::BASE_OCT, 1'b0, 7'd127, 1'b0, 1'b0, 1'b0));
        send_request(make_req(32'd12345, itoaf_pkg::BASE_DEC, 1'b1, 7'd65, 1'b1, 1'b0, 1'b0));
        send_request(make_req(32'd0, itoaf_pkg::BASE_BIN, 1'b0, 7'd64, 1'b0, 1'b1, 1'b0));
        send_request(make_req(32'd1, itoaf_pkg::BASE_BIN, 1'b0, 7'd1, 1'b0, 1'b0, 1'b0));
    endtask

    function automatic fmt_req_t random_request();
        fmt_req_t r;
        r = fmt_req_t'({$urandom, $urandom});
        case ($urandom_range(4))
            0: r.magnitude = $urandom;
            1: r.magnitude = $urandom_range(15);
            2: r.magnitude = (32'd1 << $urandom_range(31)) - 32'($urandom_range(1));
            3: r.magnitude = 32'hFFFF_FFFF - 32'($urandom_range(3));
            default: r.magnitude = $urandom_range(99999);
        endcase
        case ($urandom_range(9))
            6, 7:    r.field_width = 7'($urandom_range(40, 13));
            8:       r.field_width = 7'($urandom_range(64, 41));
            9:       r.field_width = 7'($urandom_range(127, 65));
            default: r.field_width = 7'($urandom_range(12));
        endcase
        return r;
    endfunction

    task automatic test_random_fields(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_request(random_request());
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        magnitude      <= '0;
        base_sel       <= itoaf_pkg::BASE_BIN;
        negative       <= 1'b0;
        field_width    <= '0;
        left_adjust    <= 1'b0;
        zero_pad       <= 1'b0;
        upper_case     <= 1'b0;
        char_stall     <= 1'b0;
        send_idle_pct  = 23;
        recv_stall_pct = 45;
        n_fields       = 0;
        n_chars        = 0;
        n_fail         = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_radix_extremes();
        test_padding_modes();
        test_width_limits();
        test_random_fields(140, 23, 45);
        test_random_fields(140, 45, 23);
        test_random_fields(140, 0, 0);

        req_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Formatted %0d fields, %0d characters checked: all radixes, sign and pad modes,",
                 n_fields, n_chars);
        $display("widths from zero through saturation, under mixed request idling and output stalls");
        if (n_fail == 0 && pending_chars.size() == 0)
            $display("** integer_to_ascii_formatter_core: PASSED **");
        else
            $display("** integer_to_ascii_formatter_core: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d characters outstanding", pending_chars.size());
        $display("** integer_to_ascii_formatter_core: FAILED **");
        $finish;
    end

endmodule
